>>> rtl/tsr_pkg.sv
// ----------------------------------------------------------------------------
// tsr_pkg: shared types and constants of the timed solution rotation block
// cycle tables, register indexes and pipeline stage types
// ----------------------------------------------------------------------------
package tsr_pkg;

    localparam int NUM_SOLUTIONS = 4;
    localparam int HOURS_PER_DAY = 24;
    localparam int MIN_PER_HOUR  = 60;
    localparam int PCT_FULL      = 100;

    localparam int TW = 11;   // minutes of day
    localparam int PW = 18;   // scaled minutes (x100)
    localparam int CW = 7;    // running share sum
    localparam int SW = 2;    // solution or rank index

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x below 199728
    localparam int          RECIP_SHIFT = 24;
    localparam logic [PW-1:0] RECIP_100 = PW'(167773);

    localparam logic [1:0] REG_CYCLES = 2'd0;
    localparam logic [1:0] REG_START  = 2'd1;
    localparam logic [1:0] REG_RANK   = 2'd2;
    localparam logic [1:0] REG_SHARE  = 2'd3;

    localparam logic [4:0]  RST_CYCLES = 5'd1;
    localparam logic [4:0]  RST_START  = 5'd0;
    localparam logic [7:0]  RST_RANK   = 8'd228;
    localparam logic [31:0] RST_SHARE  = 32'h1919_1919;

    typedef struct packed {
        logic                         ok;
        logic [HOURS_PER_DAY-1:0]     mask;   // hour offsets from the first start at which a cycle starts
        logic [TW-1:0]                lmin;   // cycle length in minutes
    } cycle_info_t;

    typedef struct packed {
        logic [TW-1:0]                          t;
        logic [TW-1:0]                          base;
        logic [TW-1:0]                          lmin;
        logic [HOURS_PER_DAY-1:0]               mask;
        logic [NUM_SOLUTIONS-1:0][CW-1:0]       cum;
        logic [NUM_SOLUTIONS-1:0][SW-1:0]       sol;
        logic                                   fallback;
    } s1_t;

    typedef struct packed {
        logic [TW-1:0]                          elapsed;
        logic [NUM_SOLUTIONS-1:0][PW-1:0]       cuml;
        logic [NUM_SOLUTIONS-1:0][SW-1:0]       sol;
        logic                                   fallback;
    } s2_t;

    typedef struct packed {
        logic [PW-1:0]                          e100;
        logic [NUM_SOLUTIONS-1:0][PW-1:0]       cuml;
        logic [NUM_SOLUTIONS-1:0][SW-1:0]       sol;
        logic                                   fallback;
    } s3_t;

    typedef struct packed {
        logic [PW-1:0]                          diff;
        logic [SW-1:0]                          active;
        logic                                   fallback;
    } s4_t;

    typedef struct packed {
        logic [TW-1:0]                          minutes;
        logic [SW-1:0]                          active;
        logic                                   fallback;
    } s5_t;

    function automatic cycle_info_t cycle_info(input logic [4:0] cycles);
        cycle_info_t r;
        r.ok = 1'b1;
        case (cycles)
            5'd1:    begin r.mask = 24'h000001; r.lmin = 11'd1440; end
            5'd2:    begin r.mask = 24'h001001; r.lmin = 11'd720;  end
            5'd3:    begin r.mask = 24'h010101; r.lmin = 11'd480;  end
            5'd4:    begin r.mask = 24'h041041; r.lmin = 11'd360;  end
            5'd6:    begin r.mask = 24'h111111; r.lmin = 11'd240;  end
            5'd8:    begin r.mask = 24'h249249; r.lmin = 11'd180;  end
            5'd12:   begin r.mask = 24'h555555; r.lmin = 11'd120;  end
            5'd24:   begin r.mask = 24'hFFFFFF; r.lmin = 11'd60;   end
            default: begin r.mask = 24'h000001; r.lmin = 11'd1440; r.ok = 1'b0; end
        endcase
        return r;
    endfunction

endpackage

>>> rtl/timed_solution_rotation_top.sv
// ----------------------------------------------------------------------------
// timed_solution_rotation_top: time-of-day solution rotator
// maps a (hour, minute) request to the active solution and minutes to change
// ----------------------------------------------------------------------------
// A request is taken in every cycle while the pipeline is not held, and its result
// appears on the master side through a five-stage pipeline: settings decode, elapsed
// time with share products, scaling by 100, turn selection, and division by
// 100 as a reciprocal multiply. Backpressure on the master side stalls only
// the stages that hold data. Registers are written over the APB-style port
// and must only change while no request is in flight.
module timed_solution_rotation_top
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // hour[4:0], minute[10:5]
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // active_solution[2:0], minutes_to_change[13:3]
    output logic        m_tuser,    // settings_fallback[0]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NS = tsr_pkg::NUM_SOLUTIONS;
    localparam int HD = tsr_pkg::HOURS_PER_DAY;

    logic [4:0]  cycles_reg, start_reg;
    logic [7:0]  rank_reg;
    logic [31:0] share_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    tsr_pkg::s1_t s1_reg, s1_next;
    tsr_pkg::s2_t s2_reg, s2_next;
    tsr_pkg::s3_t s3_reg, s3_next;
    tsr_pkg::s4_t s4_reg, s4_next;
    tsr_pkg::s5_t s5_reg, s5_next;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycles_reg <= tsr_pkg::RST_CYCLES;
            start_reg  <= tsr_pkg::RST_START;
            rank_reg   <= tsr_pkg::RST_RANK;
            share_reg  <= tsr_pkg::RST_SHARE;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[3:2])
                tsr_pkg::REG_CYCLES: cycles_reg <= pwdata[4:0];
                tsr_pkg::REG_START:  start_reg  <= pwdata[4:0];
                tsr_pkg::REG_RANK:   rank_reg   <= pwdata[7:0];
                tsr_pkg::REG_SHARE:  share_reg  <= pwdata;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            tsr_pkg::REG_CYCLES: prdata = {27'd0, cycles_reg};
            tsr_pkg::REG_START:  prdata = {27'd0, start_reg};
            tsr_pkg::REG_RANK:   prdata = {24'd0, rank_reg};
            tsr_pkg::REG_SHARE:  prdata = share_reg;
            default:             prdata = 32'd0;
        endcase
    end

    // pipeline flow control
    assign rdy5     = !v5_reg || m_tready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1) s1_reg <= s1_next;
        if (rdy2) s2_reg <= s2_next;
        if (rdy3) s3_reg <= s3_next;
        if (rdy4) s4_reg <= s4_next;
        if (rdy5) s5_reg <= s5_next;
    end

    // stage 1: settings decode and time of day in minutes
    always_comb
    begin
        tsr_pkg::cycle_info_t info;
        logic [NS-1:0][1:0]   rk;
        logic [NS-1:0][7:0]   sh;
        logic [NS-1:0]        seen;
        logic [9:0]           sum;
        logic [4:0]           q;
        logic [4:0]           begin_h;
        logic [6:0]           c;
        logic                 valid;

        info = tsr_pkg::cycle_info(cycles_reg);
        seen = '0;
        sum  = '0;
        for (int i = 0; i < NS; i++)
        begin
            rk[i] = rank_reg[2*i +: 2];
            sh[i] = share_reg[8*i +: 8];
            seen[rk[i]] = 1'b1;
            sum = sum + 10'(sh[i]);
        end
        valid = info.ok && (start_reg < 5'(HD)) && (&seen) &&
                (sum == 10'(tsr_pkg::PCT_FULL));

        q = '0;
        for (int j = 0; j < HD; j++)
        begin
            if (info.mask[j] && (5'(j) <= start_reg))
                q = 5'(j);
        end
        begin_h = start_reg - q;

        s1_next = '0;
        if (valid)
        begin
            s1_next.mask = info.mask;
            s1_next.lmin = info.lmin;
            for (int i = 0; i < NS; i++)
                s1_next.sol[rk[i]] = 2'(i);
        end
        else
        begin
            begin_h      = '0;
            s1_next.mask = 24'h000001;
            s1_next.lmin = 11'(HD * tsr_pkg::MIN_PER_HOUR);
            for (int i = 0; i < NS; i++)
            begin
                s1_next.sol[i] = 2'(i);
                sh[i] = 8'(tsr_pkg::PCT_FULL / NS);
            end
        end

        c = '0;
        for (int r = 0; r < NS; r++)
        begin
            c = c + 7'(sh[s1_next.sol[r]]);
            s1_next.cum[r] = c;
        end

        s1_next.t = 11'(s_tdata[4:0]) * 11'(tsr_pkg::MIN_PER_HOUR) + 11'(s_tdata[10:5]);
        s1_next.base = 11'(begin_h) * 11'(tsr_pkg::MIN_PER_HOUR);
        s1_next.fallback = !valid;
    end

    // stage 2: minutes into the cycle, share bounds in minutes x100
    always_comb
    begin
        logic [10:0] d;
        logic [10:0] off;

        d   = s1_reg.t - s1_reg.base;
        off = '0;
        for (int j = 0; j < HD; j++)
        begin
            if (s1_reg.mask[j] && (11'(j * tsr_pkg::MIN_PER_HOUR) <= d))
                off = 11'(j * tsr_pkg::MIN_PER_HOUR);
        end
        if (s1_reg.t >= s1_reg.base)
            s2_next.elapsed = d - off;
        else
            s2_next.elapsed = 11'(12'(s1_reg.t) + 12'(s1_reg.lmin) - 12'(s1_reg.base));

        for (int r = 0; r < NS; r++)
            s2_next.cuml[r] = 18'(s1_reg.cum[r]) * 18'(s1_reg.lmin);
        s2_next.sol      = s1_reg.sol;
        s2_next.fallback = s1_reg.fallback;
    end

    // stage 3: elapsed minutes x100
    always_comb
    begin
        s3_next.e100     = 18'(s2_reg.elapsed) * 18'(tsr_pkg::PCT_FULL);
        s3_next.cuml     = s2_reg.cuml;
        s3_next.sol      = s2_reg.sol;
        s3_next.fallback = s2_reg.fallback;
    end

    // stage 4: first turn whose end is not before now, boundary goes to earlier
    always_comb
    begin
        logic [1:0]  sel;
        logic [17:0] lim;

        sel = 2'(NS - 1);
        for (int r = NS - 2; r >= 0; r--)
        begin
            if (s3_reg.e100 <= s3_reg.cuml[r])
                sel = 2'(r);
        end
        lim = s3_reg.cuml[sel];
        s4_next.diff     = (lim > s3_reg.e100) ? (lim - s3_reg.e100) : '0;
        s4_next.active   = s3_reg.sol[sel];
        s4_next.fallback = s3_reg.fallback;
    end

    // stage 5: divide by 100
    always_comb
    begin
        logic [35:0] prod;

        prod = 36'(s4_reg.diff) * 36'(tsr_pkg::RECIP_100);
        s5_next.minutes  = prod[tsr_pkg::RECIP_SHIFT +: tsr_pkg::TW];
        s5_next.active   = s4_reg.active;
        s5_next.fallback = s4_reg.fallback;
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = {2'b00, s5_reg.minutes, 3'(s5_reg.active) + 3'd1};
    assign m_tuser  = s5_reg.fallback;

endmodule

>>> rtl/tsr_checker.sv
// ----------------------------------------------------------------------------
// tsr_checker: port-level checks of the timed solution rotation block
// result ranges, configuration port readiness and master-side hold behaviour
// ----------------------------------------------------------------------------
module tsr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        pready
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_active: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] != 3'd0) && (m_tdata[2:0] <= 3'd4))
        else $error("active solution out of range");

    a_minutes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[13:3] <= 11'd1440) && (m_tdata[15:14] == 2'b00))
        else $error("minutes to change out of range");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("configuration port not ready");

endmodule

bind timed_solution_rotation_top tsr_checker u_tsr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pready   (pready)
);

>>> dv/tb_timed_solution_rotation_top.sv
// ----------------------------------------------------------------------------
// tb_timed_solution_rotation_top: self-checking bench of the solution rotator
// drives hour/minute requests on the slave stream under a series of register
// settings (valid, extreme and invalid) and checks every master-side result against
// row values or a predictor of active solution, minutes to change and fallback
// ----------------------------------------------------------------------------
module tb_timed_solution_rotation_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SOLUTIONS = tsr_pkg::NUM_SOLUTIONS;
    localparam int HOURS_PER_DAY = tsr_pkg::HOURS_PER_DAY;
    localparam int MIN_PER_HOUR  = tsr_pkg::MIN_PER_HOUR;
    localparam int PCT_FULL      = tsr_pkg::PCT_FULL;

    localparam logic [1:0]  REG_CYCLES = tsr_pkg::REG_CYCLES;
    localparam logic [1:0]  REG_START  = tsr_pkg::REG_START;
    localparam logic [1:0]  REG_RANK   = tsr_pkg::REG_RANK;
    localparam logic [1:0]  REG_SHARE  = tsr_pkg::REG_SHARE;

    localparam logic [4:0]  RST_CYCLES = tsr_pkg::RST_CYCLES;
    localparam logic [4:0]  RST_START  = tsr_pkg::RST_START;
    localparam logic [7:0]  RST_RANK   = tsr_pkg::RST_RANK;
    localparam logic [31:0] RST_SHARE  = tsr_pkg::RST_SHARE;

    localparam int LATENCY      = 5;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 64;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 40;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed {
        logic [2:0]  solution;
        logic [10:0] minutes;
        logic        fallback;
    } rotation_t;

    typedef enum logic [1:0] {ROW_QUERY, ROW_CHECKED, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [4:0]  hr;
        logic [5:0]  mn;
        logic [1:0]  regsel;
        logic [31:0] value;
        logic [2:0]  sol;
        logic [10:0] mins;
        logic        fb;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [4:0]  cfg_cycles;
    logic [4:0]  cfg_start;
    logic [7:0]  cfg_rank;
    logic [31:0] cfg_share;

    logic        pin_valid;
    rotation_t   pin_want;

    rotation_t   results_due [$];
    row_t        directed_rows [$];

    int          mismatches;
    int          requests_sent;
    int          results_checked;
    int          fallback_results;
    int          stuck_cycles;
    bit          src_idle;
    bit          sink_idle;
    bit          hold_pending;

    timed_solution_rotation_top DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic rotation_t rotation_predict(input logic [4:0] hr, input logic [5:0] mn);
        rotation_t   r;
        int unsigned rank [NUM_SOLUTIONS];
        int unsigned share [NUM_SOLUTIONS];
        int unsigned order [NUM_SOLUTIONS];
        int unsigned seen, total, cyc, hpc, begin_hr, lmin, t, base, stage, el, acc, pick;
        bit          ok;
        bit          found;
        seen  = 0;
        total = 0;
        for (int i = 0; i < NUM_SOLUTIONS; i++)
        begin
            rank[i]  = cfg_rank[2*i +: 2];
            share[i] = cfg_share[8*i +: 8];
            seen     = seen | (1 << rank[i]);
            total    = total + share[i];
        end
        ok = cfg_cycles != 0 && (HOURS_PER_DAY % cfg_cycles) == 0 &&
             cfg_start < HOURS_PER_DAY && seen == 15 && total == PCT_FULL;
        if (ok)
        begin
            cyc      = cfg_cycles;
            hpc      = HOURS_PER_DAY / cyc;
            begin_hr = cfg_start % hpc;
        end
        else
        begin
            cyc      = 1;
            hpc      = HOURS_PER_DAY;
            begin_hr = 0;
            for (int i = 0; i < NUM_SOLUTIONS; i++)
            begin
                rank[i]  = i;
                share[i] = PCT_FULL / NUM_SOLUTIONS;
            end
        end
        for (int i = 0; i < NUM_SOLUTIONS; i++)
            order[rank[i]] = i;
        lmin = hpc * MIN_PER_HOUR;
        t    = hr * MIN_PER_HOUR + mn;
        base = begin_hr * MIN_PER_HOUR;
        if (t >= base)
        begin
            stage = (t - base) / lmin;
            if (stage > cyc - 1)
                stage = cyc - 1;
            el = t - base - stage * lmin;
        end
        else
            el = t + lmin - base;
        acc   = 0;
        pick  = order[NUM_SOLUTIONS-1];
        found = 1'b0;
        for (int i = 0; i < NUM_SOLUTIONS; i++)
        begin
            if (!found)
            begin
                acc = acc + share[order[i]];
                if (i == NUM_SOLUTIONS - 1 || el * PCT_FULL <= acc * lmin)
                begin
                    pick  = order[i];
                    found = 1'b1;
                end
            end
        end
        r.solution = 3'(pick + 1);
        r.minutes  = (acc * lmin > el * PCT_FULL) ? 11'((acc * lmin - el * PCT_FULL) / PCT_FULL)
                                                  : 11'd0;
        r.fallback = !ok;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch %0d at %0t: %s got %0d want %0d", mismatches, $realtime, what,
                     got, want);
    endtask

    always @(posedge clk)
    begin
        rotation_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                want = pin_valid ? pin_want : rotation_predict(s_tdata[4:0], s_tdata[10:5]);
                results_due.push_back(want);
                requests_sent++;
            end
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                    flag_mismatch("unexpected result, solution", m_tdata[2:0], 0);
                else
                begin
                    want = results_due.pop_front();
                    results_checked++;
                    if (want.fallback)
                        fallback_results++;
                    if (m_tdata[2:0] !== want.solution)
                        flag_mismatch("active_solution", m_tdata[2:0], want.solution);
                    if (m_tdata[13:3] !== want.minutes)
                        flag_mismatch("minutes_to_change", m_tdata[13:3], want.minutes);
                    if (m_tuser !== want.fallback)
                        flag_mismatch("settings_fallback", m_tuser, want.fallback);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // sink side: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                m_tready <= 1'b1;
            end
            else if (sink_idle && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_request(input logic [4:0] hr, input logic [5:0] mn, input bit checked,
                                input rotation_t want);
        if (src_idle && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {5'b0, mn, hr};
        pin_valid <= checked;
        pin_want  <= want;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pause_stream();
        s_tvalid  <= 1'b0;
        pin_valid <= 1'b0;
        @(negedge clk);
        while (results_due.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    task automatic program_register(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CYCLES: cfg_cycles = value[4:0];
            REG_START:  cfg_start  = value[4:0];
            REG_RANK:   cfg_rank   = value[7:0];
            default:    cfg_share  = value;
        endcase
        @(negedge clk);
    endtask

    initial
    begin
        int          p, n, k, tmp;
        int          perm [NUM_SOLUTIONS];
        int          cut [3];
        logic [4:0]  hr;
        logic [5:0]  mn;
        logic [31:0] new_cfg [NUM_SOLUTIONS];
        row_t        row;
        rotation_t   want;

        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pin_valid = 1'b0;
        pin_want = '0;
        cfg_cycles = RST_CYCLES;
        cfg_start = RST_START;
        cfg_rank = RST_RANK;
        cfg_share = RST_SHARE;
        mismatches = 0;
        requests_sent = 0;
        results_checked = 0;
        fallback_results = 0;
        stuck_cycles = 0;
        src_idle = 1'b1;
        sink_idle = 1'b1;
        hold_pending = 1'b0;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: boundaries, day end, out-of-range fields
        directed_rows.push_back('{ROW_CHECKED, 5'd0, 6'd0, REG_CYCLES, 32'd0, 3'd1, 11'd360, 1'b0});
        directed_rows.push_back('{ROW_CHECKED, 5'd23, 6'd59, REG_CYCLES, 32'd0, 3'd4, 11'd1, 1'b0});
        directed_rows.push_back('{ROW_CHECKED, 5'd6, 6'd0, REG_CYCLES, 32'd0, 3'd1, 11'd0, 1'b0});
        directed_rows.push_back('{ROW_CHECKED, 5'd6, 6'd1, REG_CYCLES, 32'd0, 3'd2, 11'd359, 1'b0});
        directed_rows.push_back('{ROW_CHECKED, 5'd12, 6'd0, REG_CYCLES, 32'd0, 3'd2, 11'd0, 1'b0});
        directed_rows.push_back('{ROW_CHECKED, 5'd18, 6'd0, REG_CYCLES, 32'd0, 3'd3, 11'd0, 1'b0});
        directed_rows.push_back('{ROW_CHECKED, 5'd31, 6'd63, REG_CYCLES, 32'd0, 3'd4, 11'd0, 1'b0});
        directed_rows.push_back('{ROW_CHECKED, 5'd0, 6'd63, REG_CYCLES, 32'd0, 3'd1, 11'd297, 1'b0});
        // quarter-day cycles from hour 5: time before the first start wraps into the last cycle
        directed_rows.push_back('{ROW_WRITE, 5'd0, 6'd0, REG_CYCLES, 32'd4, 3'd0, 11'd0, 1'b0});
        directed_rows.push_back('{ROW_WRITE, 5'd0, 6'd0, REG_START, 32'd5, 3'd0, 11'd0, 1'b0});
        directed_rows.push_back('{ROW_QUERY, 5'd2, 6'd0, REG_CYCLES, 32'd0, 3'd0, 11'd0, 1'b0});
        directed_rows.push_back('{ROW_QUERY, 5'd4, 6'd59, REG_CYCLES, 32'd0, 3'd0, 11'd0, 1'b0});
        directed_rows.push_back('{ROW_QUERY, 5'd5, 6'd0, REG_CYCLES, 32'd0, 3'd0, 11'd0, 1'b0});
        directed_rows.push_back('{ROW_QUERY, 5'd29, 6'd10, REG_CYCLES, 32'd0, 3'd0, 11'd0, 1'b0});
        // reversed ranks with zero shares at both ends of the order
        directed_rows.push_back('{ROW_WRITE, 5'd0, 6'd0, REG_RANK, 32'h1B, 3'd0, 11'd0, 1'b0});
        directed_rows.push_back('{ROW_WRITE, 5'd0, 6'd0, REG_SHARE, 32'h003C_2800, 3'd0, 11'd0,
                                  1'b0});
        directed_rows.push_back('{ROW_QUERY, 5'd5, 6'd0, REG_CYCLES, 32'd0, 3'd0, 11'd0, 1'b0});
        directed_rows.push_back('{ROW_QUERY, 5'd23, 6'd59, REG_CYCLES, 32'd0, 3'd0, 11'd0, 1'b0});
        directed_rows.push_back('{ROW_QUERY, 5'd8, 6'd36, REG_CYCLES, 32'd0, 3'd0, 11'd0, 1'b0});
        directed_rows.push_back('{ROW_QUERY, 5'd10, 6'd59, REG_CYCLES, 32'd0, 3'd0, 11'd0, 1'b0});
        // invalid settings fall back to the defaults
        directed_rows.push_back('{ROW_WRITE, 5'd0, 6'd0, REG_CYCLES, 32'd5, 3'd0, 11'd0, 1'b0});
        directed_rows.push_back('{ROW_CHECKED, 5'd0, 6'd0, REG_CYCLES, 32'd0, 3'd1, 11'd360, 1'b1});
        directed_rows.push_back('{ROW_CHECKED, 5'd23, 6'd59, REG_CYCLES, 32'd0, 3'd4, 11'd1, 1'b1});
        directed_rows.push_back('{ROW_WRITE, 5'd0, 6'd0, REG_CYCLES, 32'd24, 3'd0, 11'd0, 1'b0});
        directed_rows.push_back('{ROW_WRITE, 5'd0, 6'd0, REG_START, 32'd31, 3'd0, 11'd0, 1'b0});
        directed_rows.push_back('{ROW_CHECKED, 5'd12, 6'd30, REG_CYCLES, 32'd0, 3'd3, 11'd330, 1'b1});

        foreach (directed_rows[i])
        begin
            row  = directed_rows[i];
            want = {row.sol, row.mins, row.fb};
            if (row.kind == ROW_WRITE)
            begin
                pause_stream();
                program_register(row.regsel, row.value);
            end
            else
                send_request(row.hr, row.mn, row.kind == ROW_CHECKED, want);
        end

        for (p = 0; p < NUM_PHASES; p++)
        begin
            pause_stream();
            if (p == 0)
                new_cfg = '{32'd24, 32'd23, 32'hE4, 32'h0000_0064};
            else if (p == 1)
                new_cfg = '{32'd1, 32'd0, 32'h1B, 32'h6400_0000};
            else if (p == 2)
                new_cfg = '{32'd31, 32'd31, 32'hFF, 32'hFFFF_FFFF};
            else if ($urandom_range(0, 3) == 0)
                new_cfg = '{$urandom_range(0, 31), $urandom_range(0, 31),
                            $urandom_range(0, 255), $urandom};
            else
            begin
                case ($urandom_range(0, 7))
                    0:       new_cfg[REG_CYCLES] = 1;
                    1:       new_cfg[REG_CYCLES] = 2;
                    2:       new_cfg[REG_CYCLES] = 3;
                    3:       new_cfg[REG_CYCLES] = 4;
                    4:       new_cfg[REG_CYCLES] = 6;
                    5:       new_cfg[REG_CYCLES] = 8;
                    6:       new_cfg[REG_CYCLES] = 12;
                    default: new_cfg[REG_CYCLES] = 24;
                endcase
                new_cfg[REG_START] = $urandom_range(0, 23);
                for (k = 0; k < NUM_SOLUTIONS; k++)
                    perm[k] = k;
                for (k = NUM_SOLUTIONS - 1; k > 0; k--)
                begin
                    n       = $urandom_range(0, k);
                    tmp     = perm[k];
                    perm[k] = perm[n];
                    perm[n] = tmp;
                end
                new_cfg[REG_RANK] = {24'b0, 2'(perm[3]), 2'(perm[2]), 2'(perm[1]), 2'(perm[0])};
                tmp = $urandom_range(0, 1);
                for (k = 0; k < 3; k++)
                    cut[k] = tmp ? $urandom_range(0, 20) * 5 : $urandom_range(0, PCT_FULL);
                if (cut[0] > cut[1]) begin tmp = cut[0]; cut[0] = cut[1]; cut[1] = tmp; end
                if (cut[1] > cut[2]) begin tmp = cut[1]; cut[1] = cut[2]; cut[2] = tmp; end
                if (cut[0] > cut[1]) begin tmp = cut[0]; cut[0] = cut[1]; cut[1] = tmp; end
                new_cfg[REG_SHARE] = {8'(PCT_FULL - cut[2]), 8'(cut[2] - cut[1]),
                                      8'(cut[1] - cut[0]), 8'(cut[0])};
            end
            program_register(REG_CYCLES, new_cfg[REG_CYCLES]);
            program_register(REG_START, new_cfg[REG_START]);
            program_register(REG_RANK, new_cfg[REG_RANK]);
            program_register(REG_SHARE, new_cfg[REG_SHARE]);

            src_idle  = (p != 4) && (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            sink_idle = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            if (p == 4)
                hold_pending = 1'b1;

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                k = $urandom_range(0, 19);
                if (k == 0)
                begin
                    hr = $urandom_range(0, 31);
                    mn = $urandom_range(0, 63);
                end
                else
                begin
                    hr = $urandom_range(0, 23);
                    mn = (k < 4) ? 6'd0 : 6'($urandom_range(0, 59));
                end
                send_request(hr, mn, 1'b0, '0);
            end
        end

        pause_stream();
        repeat (2 * LATENCY) @(negedge clk);
        if (results_due.size() != 0)
            flag_mismatch("results still outstanding", results_due.size(), 0);

        $display("covered %0d requests over %0d register settings, %0d results compared",
                 requests_sent, NUM_PHASES + 5, results_checked);
        $display("%0d results under fallback settings, %0d mismatches", fallback_results,
                 mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
